/* hdl/led_matrix_scan_controller_defines.svh */
// Assertion macros for the LED matrix scan controller.
`ifndef LED_MATRIX_SCAN_CONTROLLER_DEFINES_SVH
`define LED_MATRIX_SCAN_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked at every edge except while reset is held.
`define LMSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LMSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LMSC_ASSERT(lbl, clk, rst, prop, msg)
`define LMSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/lmsc_pkg.sv */
// Shared constants, codes and types for the LED matrix scan controller.
`default_nettype none

package lmsc_pkg;

   localparam int PANEL_ROWS  = 32;
   localparam int PANEL_COLS  = 64;
   localparam int STORE_DEPTH = PANEL_ROWS * PANEL_COLS;
   localparam int HALF_ROWS   = PANEL_ROWS / 2;

   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int PASS_W  = $clog2(PANEL_ROWS);
   localparam int COL_W   = (PANEL_COLS > 1) ? $clog2(PANEL_COLS) : 1;
   localparam int RADDR_W = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

   localparam int KIND_W      = 2;
   localparam int PIX_ROW_W   = 5;
   localparam int PIX_COL_W   = 6;
   localparam int COLOR_W     = 3;
   localparam int ROW_ADDR_W  = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_SCAN  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [PASS_W-1:0]  pass;
      logic [COL_W-1:0]   column;
      logic [RADDR_W-1:0] row_addr;
      logic               upper;
      logic               last_col;
      logic               last_pass;
   } scan_pos_type;

   typedef struct packed {
      logic [RADDR_W-1:0] row_addr;
      logic               upper;
      logic               last_col;
      logic               frame_end;
   } rsp_meta_type;

endpackage

`default_nettype wire

/* hdl/lmsc_if.sv */
// Request and response channel interfaces of the LED matrix scan controller.
`default_nettype none

interface lmsc_req_if;
   logic                            valid;
   logic                            ready;
   logic [lmsc_pkg::KIND_W-1:0]     kind;
   logic [lmsc_pkg::PIX_ROW_W-1:0]  pixel_row;
   logic [lmsc_pkg::PIX_COL_W-1:0]  pixel_col;
   logic [lmsc_pkg::COLOR_W-1:0]    pixel_color;

   modport source (output valid, kind, pixel_row, pixel_col, pixel_color, input ready);
   modport sink   (input valid, kind, pixel_row, pixel_col, pixel_color, output ready);
endinterface

interface lmsc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lmsc_pkg::COLOR_W-1:0]     top_color;
   logic [lmsc_pkg::COLOR_W-1:0]     bottom_color;
   logic                             latch_row;
   logic [lmsc_pkg::ROW_ADDR_W-1:0]  row_address;
   logic                             frame_end;

   modport source (output valid, top_color, bottom_color, latch_row, row_address,
                   frame_end, input ready);
   modport sink   (input valid, top_color, bottom_color, latch_row, row_address,
                   frame_end, output ready);
endinterface

`default_nettype wire

/* hdl/led_matrix_scan_controller.sv */
// Scan result: valid in the cycle after the tick transfer, from the registered frame store read.
// Writes and ticks: one item per cycle; any item waits while clearing or while an untaken result holds the slot.
// Clear: zeroes every store entry, one per cycle on the single write port; no request transfers.
// Reset: scan position to zero, then the same clearing sweep of the store.
// Read after write needs no bypass: a write commits at its transfer edge, reads come later.
`default_nettype none

`include "led_matrix_scan_controller_defines.svh"

module led_matrix_scan_controller (
   input  wire logic  clock,
   input  wire logic  reset,
   lmsc_req_if.sink   req_bus,
   lmsc_rsp_if.source rsp_bus
);

   logic [lmsc_pkg::COLOR_W-1:0] store_mem [lmsc_pkg::STORE_DEPTH];

   logic                         clear_busy_ff, clear_busy_in;
   logic [lmsc_pkg::ADDR_W-1:0]  clear_ptr_ff,  clear_ptr_in;
   logic                         rsp_valid_ff,  rsp_valid_in;
   lmsc_pkg::rsp_meta_type       meta_ff;
   logic [lmsc_pkg::COLOR_W-1:0] rd_data_ff;

   lmsc_pkg::scan_pos_type       pos;
   logic                         req_accept;
   logic                         scan_accept;
   logic                         clear_accept;
   logic                         pix_in_panel;
   logic [lmsc_pkg::ADDR_W-1:0]  pix_addr;
   logic [lmsc_pkg::ADDR_W-1:0]  rd_addr;
   logic                         wr_en;
   logic [lmsc_pkg::ADDR_W-1:0]  wr_addr;
   logic [lmsc_pkg::COLOR_W-1:0] wr_data;
   logic                         clear_last;

   assign req_bus.ready = !clear_busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign scan_accept   = req_accept && (req_bus.kind == lmsc_pkg::KIND_SCAN);
   assign clear_accept  = req_accept && (req_bus.kind == lmsc_pkg::KIND_CLEAR);

   assign pix_in_panel = (32'(req_bus.pixel_row) < 32'(lmsc_pkg::PANEL_ROWS)) &&
                         (32'(req_bus.pixel_col) < 32'(lmsc_pkg::PANEL_COLS));
   assign pix_addr = lmsc_pkg::ADDR_W'(32'(req_bus.pixel_row) * 32'(lmsc_pkg::PANEL_COLS) +
                                       32'(req_bus.pixel_col));
   assign rd_addr  = lmsc_pkg::ADDR_W'(32'(pos.pass) * 32'(lmsc_pkg::PANEL_COLS) +
                                       32'(pos.column));

   lmsc_scan_pos u_scan_pos (
      .clock   (clock),
      .reset   (reset),
      .advance (scan_accept),
      .pos     (pos)
   );

   // single write port: clearing sweep has it, otherwise pixel writes
   always_comb begin
      if (clear_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_ptr_ff;
         wr_data = '0;
      end else begin
         wr_en   = req_accept && (req_bus.kind == lmsc_pkg::KIND_WRITE) && pix_in_panel;
         wr_addr = pix_addr;
         wr_data = req_bus.pixel_color;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_accept) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign clear_last = clear_ptr_ff == lmsc_pkg::ADDR_W'(lmsc_pkg::STORE_DEPTH - 1);

   always_comb begin
      priority if (clear_busy_ff) begin
         clear_busy_in = !clear_last;
         clear_ptr_in  = clear_last ? '0 : clear_ptr_ff + 1'b1;
      end else if (clear_accept) begin
         clear_busy_in = 1'b1;
         clear_ptr_in  = '0;
      end else begin
         clear_busy_in = clear_busy_ff;
         clear_ptr_in  = clear_ptr_ff;
      end
   end

   always_comb begin
      priority if (scan_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_ptr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_ptr_ff  <= clear_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_accept) begin
         meta_ff.row_addr  <= pos.row_addr;
         meta_ff.upper     <= pos.upper;
         meta_ff.last_col  <= pos.last_col;
         meta_ff.frame_end <= pos.last_col && pos.last_pass;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.top_color    = meta_ff.upper ? rd_data_ff : '0;
   assign rsp_bus.bottom_color = meta_ff.upper ? '0 : rd_data_ff;
   assign rsp_bus.latch_row    = meta_ff.last_col;
   assign rsp_bus.row_address  = lmsc_pkg::ROW_ADDR_W'(meta_ff.row_addr);
   assign rsp_bus.frame_end    = meta_ff.frame_end;

   `LMSC_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> clear_busy_ff, "no clear after reset")
   `LMSC_ASSERT(a_tick_gives_result, clock, reset, scan_accept |=> rsp_valid_ff, "tick lost")
   `LMSC_ASSERT(a_frame_end_latches, clock, reset,
                (rsp_valid_ff && meta_ff.frame_end) |-> meta_ff.last_col, "frame end off row")
   `LMSC_ASSERT(a_clear_ends_at_zero, clock, reset,
                $fell(clear_busy_ff) |-> (clear_ptr_ff == '0), "clear pointer not idle")

endmodule

`default_nettype wire

/* hdl/lmsc_scan_pos.sv */
// Scan position counters: column, pass and panel row address.
`default_nettype none

module lmsc_scan_pos (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   output lmsc_pkg::scan_pos_type      pos
);

   logic [lmsc_pkg::PASS_W-1:0]  pass_ff,     pass_in;
   logic [lmsc_pkg::COL_W-1:0]   column_ff,   column_in;
   logic [lmsc_pkg::RADDR_W-1:0] row_addr_ff, row_addr_in;
   logic                         last_col;
   logic                         last_pass;
   logic                         last_raddr;

   assign last_col   = column_ff == lmsc_pkg::COL_W'(lmsc_pkg::PANEL_COLS - 1);
   assign last_pass  = pass_ff == lmsc_pkg::PASS_W'(lmsc_pkg::PANEL_ROWS - 1);
   assign last_raddr = row_addr_ff == lmsc_pkg::RADDR_W'(lmsc_pkg::HALF_ROWS - 1);

   always_comb begin
      pass_in     = pass_ff;
      column_in   = column_ff;
      row_addr_in = row_addr_ff;
      if (advance) begin
         if (last_col) begin
            column_in = '0;
            if (last_pass) begin
               pass_in     = '0;
               row_addr_in = '0;
            end else begin
               pass_in     = pass_ff + 1'b1;
               row_addr_in = last_raddr ? '0 : row_addr_ff + 1'b1;
            end
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff     <= '0;
         column_ff   <= '0;
         row_addr_ff <= '0;
      end else begin
         pass_ff     <= pass_in;
         column_ff   <= column_in;
         row_addr_ff <= row_addr_in;
      end
   end

   always_comb begin
      pos.pass      = pass_ff;
      pos.column    = column_ff;
      pos.row_addr  = row_addr_ff;
      pos.upper     = pass_ff < lmsc_pkg::PASS_W'(lmsc_pkg::HALF_ROWS);
      pos.last_col  = last_col;
      pos.last_pass = last_pass;
   end

endmodule

`default_nettype wire
